@@ sv/gcoin_pkg.sv @@
package gcoin_pkg;

  // Table geometry and value width.
  localparam int MAX_COIN_KINDS = 16;
  localparam int VALUE_BITS     = 16;
  localparam int IDX_W          = $clog2(MAX_COIN_KINDS);
  localparam int BIT_W          = $clog2(VALUE_BITS);
  localparam int KIND_W         = 5;
  localparam int COUNT_W        = 16;

  // Input action codes.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_CHANGE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_SEND
  } gcoin_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             tbl_we;
    logic             req_start;
    logic             fetch;
    logic             div_step;
    logic             store;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
  } gcoin_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic d_zero;
  } gcoin_sts_t;

endpackage

@@ sv/gcoin_ctrl.sv @@
module gcoin_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_action,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gcoin_pkg::IDX_W-1:0]        out_coin_slot,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [gcoin_pkg::KIND_W-1:0]       cfg_data,
  input  gcoin_pkg::gcoin_sts_t              sts,
  output gcoin_pkg::gcoin_cmd_t              cmd
);

  gcoin_pkg::gcoin_state_t            state_r, state_nxt;
  logic [gcoin_pkg::KIND_W-1:0]       kinds_r;
  logic [gcoin_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [gcoin_pkg::BIT_W-1:0]        bit_r, bit_nxt;
  logic [gcoin_pkg::IDX_W-1:0]        k_last;
  logic                               in_acc;
  logic                               out_acc;

  // Highest index in use, with the register clamped to the table size.
  always_comb begin
    priority if (kinds_r == '0) begin
      k_last = '0;
    end else if (kinds_r > gcoin_pkg::KIND_W'(gcoin_pkg::MAX_COIN_KINDS)) begin
      k_last = gcoin_pkg::IDX_W'(gcoin_pkg::MAX_COIN_KINDS - 1);
    end else begin
      k_last = gcoin_pkg::IDX_W'(kinds_r - gcoin_pkg::KIND_W'(1));
    end
  end

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      gcoin_pkg::ST_IDLE: begin
        if (in_acc && in_action == gcoin_pkg::ACT_CHANGE) begin
          idx_nxt   = k_last;
          state_nxt = gcoin_pkg::ST_FETCH;
        end
      end
      gcoin_pkg::ST_FETCH: begin
        bit_nxt   = '0;
        state_nxt = gcoin_pkg::ST_DIV;
      end
      gcoin_pkg::ST_DIV: begin
        // A zero denomination skips the division entirely.
        if (sts.d_zero || bit_r == gcoin_pkg::BIT_W'(gcoin_pkg::VALUE_BITS - 1)) begin
          state_nxt = gcoin_pkg::ST_STORE;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      gcoin_pkg::ST_STORE: begin
        if (idx_r == '0) begin
          state_nxt = gcoin_pkg::ST_READ;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = gcoin_pkg::ST_FETCH;
        end
      end
      gcoin_pkg::ST_READ: begin
        state_nxt = gcoin_pkg::ST_SEND;
      end
      gcoin_pkg::ST_SEND: begin
        if (out_acc) begin
          if (idx_r == k_last) begin
            state_nxt = gcoin_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = gcoin_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = gcoin_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd           = '0;
    cmd.idx       = idx_r;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    unique case (state_r)
      gcoin_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.tbl_we    = in_valid && in_action == gcoin_pkg::ACT_LOAD;
        cmd.req_start = in_valid && in_action == gcoin_pkg::ACT_CHANGE;
      end
      gcoin_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      gcoin_pkg::ST_DIV: begin
        cmd.div_step = !sts.d_zero;
      end
      gcoin_pkg::ST_STORE: begin
        cmd.store = 1'b1;
      end
      gcoin_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      gcoin_pkg::ST_SEND: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_coin_slot = idx_r;
  assign out_last      = (idx_r == k_last);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcoin_pkg::ST_IDLE;
      kinds_r <= gcoin_pkg::KIND_W'(1);
      idx_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bit_r   <= bit_nxt;
      if (cfg_we) begin
        kinds_r <= cfg_data;
      end
    end
  end

endmodule

@@ sv/gcoin_dp.sv @@
module gcoin_dp (
  input  logic                                clk,
  input  gcoin_pkg::gcoin_cmd_t               cmd,
  input  logic [gcoin_pkg::IDX_W-1:0]         in_slot,
  input  logic [gcoin_pkg::VALUE_BITS-1:0]    in_amount,
  output gcoin_pkg::gcoin_sts_t               sts,
  output logic [gcoin_pkg::COUNT_W-1:0]       out_coin_count,
  output logic [gcoin_pkg::VALUE_BITS-1:0]    out_unpaid
);

  localparam int VW = gcoin_pkg::VALUE_BITS;

  logic [VW-1:0]                 denom_mem [gcoin_pkg::MAX_COIN_KINDS];
  logic [gcoin_pkg::COUNT_W-1:0] count_mem [gcoin_pkg::MAX_COIN_KINDS];

  logic [VW-1:0]                 d_r;
  logic [VW-1:0]                 rem_r;
  logic [VW-1:0]                 part_r;
  logic [VW-1:0]                 quo_r;
  logic [gcoin_pkg::COUNT_W-1:0] rd_r;
  logic [VW:0]                   shifted;
  logic [VW:0]                   diff;

  assign sts.d_zero = (d_r == '0);

  // One restoring division step: shift in the next dividend bit and try a subtract.
  assign shifted = {part_r, quo_r[VW-1]};
  assign diff    = shifted - {1'b0, d_r};

  // Denomination table: written by loads, read once per walk step.
  always_ff @(posedge clk) begin
    if (cmd.tbl_we && 32'(in_slot) < gcoin_pkg::MAX_COIN_KINDS) begin
      denom_mem[in_slot] <= in_amount;
    end
    if (cmd.fetch) begin
      d_r <= denom_mem[cmd.idx];
    end
  end

  // Count table: every index in use is written during the walk, then read out.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      count_mem[cmd.idx] <= sts.d_zero ? '0 : gcoin_pkg::COUNT_W'(quo_r);
    end
    if (cmd.rd_en) begin
      rd_r <= count_mem[cmd.idx];
    end
  end

  // Running remainder and the shared divider.
  always_ff @(posedge clk) begin
    if (cmd.req_start) begin
      rem_r <= in_amount;
    end else if (cmd.store && !sts.d_zero) begin
      rem_r <= part_r;
    end
    if (cmd.fetch) begin
      part_r <= '0;
      quo_r  <= rem_r;
    end else if (cmd.div_step) begin
      if (!diff[VW]) begin
        part_r <= diff[VW-1:0];
        quo_r  <= {quo_r[VW-2:0], 1'b1};
      end else begin
        part_r <= shifted[VW-1:0];
        quo_r  <= {quo_r[VW-2:0], 1'b0};
      end
    end
  end

  assign out_coin_count = rd_r;
  assign out_unpaid     = rem_r;

endmodule

@@ sv/greedy_coin_change.sv @@
// Greedy change maker. A load word (action 0) writes a denomination into slot
// in_slot of a sixteen-entry table. A change word (action 1) walks the table
// from index coin_kinds-1 (the register clamped to 1..16) down to 0, dividing the
// running amount by each nonzero denomination with a shared one-bit-per-cycle
// restoring divider, then sends one result word per index in ascending order.
// Each nonzero denomination takes a fetch, sixteen divide steps and a store; a
// zero denomination takes a fetch and a store with no divide step; each result
// word is read from the count table and then sent. Only one request is in
// flight, and no input word is taken until the last result word has left.
module greedy_coin_change (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [gcoin_pkg::IDX_W-1:0]         in_slot,
  input  logic [gcoin_pkg::VALUE_BITS-1:0]    in_amount,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gcoin_pkg::IDX_W-1:0]         out_coin_slot,
  output logic [gcoin_pkg::COUNT_W-1:0]       out_coin_count,
  output logic [gcoin_pkg::VALUE_BITS-1:0]    out_unpaid,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [gcoin_pkg::KIND_W-1:0]        cfg_data
);

  gcoin_pkg::gcoin_cmd_t cmd;
  gcoin_pkg::gcoin_sts_t sts;

  // Sequencer.
  gcoin_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_coin_slot (out_coin_slot),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Tables, divider and result registers.
  gcoin_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_slot        (in_slot),
    .in_amount      (in_amount),
    .sts            (sts),
    .out_coin_count (out_coin_count),
    .out_unpaid     (out_unpaid)
  );

  // No input word is taken while a result word is on offer.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("input word accepted while a result word is pending");

  // After the final result word leaves, the block is ready again.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !in_stall)
    else $error("block not ready after the last result word");

  // Result words of one request come in ascending slot order.
  a_slot_ascends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> ##1
      (out_valid &&
       out_coin_slot == $past(out_coin_slot, 2) + gcoin_pkg::IDX_W'(1)))
    else $error("result slot did not advance by one");

  // The unpaid amount stays fixed across the result words of a request.
  a_unpaid_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> ##1 $stable(out_unpaid))
    else $error("unpaid amount changed within a request");

endmodule

@@ sim/greedy_coin_change_tb.sv @@
`timescale 1ns / 100ps

module greedy_coin_change_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int NUM_ROWS = 18;
  localparam int NUM_PHASES = 9;
  localparam int WORDS_PER_PHASE = 22;

  // One expected result word of a change request.
  typedef struct packed {
    logic [3:0]  coin_slot;
    logic [15:0] coin_count;
    logic [15:0] unpaid;
    logic        last;
  } coin_word_t;

  // One row of the directed stimulus; a kinds row carries the register value in amount.
  typedef struct packed {
    logic        is_kinds;
    logic        action;
    logic [3:0]  slot;
    logic [15:0] amount;
    logic        typed;
    logic [15:0] exp_count;
    logic [15:0] exp_unpaid;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = gcoin_pkg::ACT_LOAD;
  logic [3:0]  in_slot = '0;
  logic [15:0] in_amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_coin_slot;
  logic [15:0] out_coin_count;
  logic [15:0] out_unpaid;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;

  // Mirror of the block state used for prediction.
  logic [15:0] denom_tbl [gcoin_pkg::MAX_COIN_KINDS];
  logic [gcoin_pkg::MAX_COIN_KINDS-1:0] written = '0;
  logic [4:0]  kinds_reg = 5'd1;

  coin_word_t  expected_coins [$];
  coin_word_t  head;
  int          fails = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Directed words: extremes of the fields, zero coins, clamped and unordered tables.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd0,  16'd1,     1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd0,  16'd0,     1'b1, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd0,  16'd65535, 1'b1, 16'd65535, 16'd0},
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd0,  16'd65535, 1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd15, 16'd65535, 1'b1, 16'd1,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd0,  16'd65534, 1'b1, 16'd0,     16'd65534},
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd0,  16'd0,     1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd0,  16'd777,   1'b1, 16'd0,     16'd777},
    '{1'b1, gcoin_pkg::ACT_LOAD,   4'd0,  16'd0,     1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd0,  16'd7,     1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd0,  16'd20,    1'b1, 16'd2,     16'd6},
    '{1'b1, gcoin_pkg::ACT_LOAD,   4'd0,  16'd3,     1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd1,  16'd5,     1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd2,  16'd10,    1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd0,  16'd27,    1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_LOAD,   4'd15, 16'd65535, 1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd5,  16'd65535, 1'b0, 16'd0,     16'd0},
    '{1'b0, gcoin_pkg::ACT_CHANGE, 4'd10, 16'd0,     1'b0, 16'd0,     16'd0}
  };

  // Register values per random phase, extremes included.
  logic [4:0] phase_kinds [NUM_PHASES] = '{5'd16, 5'd5, 5'd31, 5'd0, 5'd12, 5'd17, 5'd1,
                                           5'd16, 5'd2};

  greedy_coin_change dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_slot        (in_slot),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coin_slot  (out_coin_slot),
    .out_coin_count (out_coin_count),
    .out_unpaid     (out_unpaid),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Register values of 0 and above the table size are clamped.
  function automatic int active_kinds(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > gcoin_pkg::MAX_COIN_KINDS) return gcoin_pkg::MAX_COIN_KINDS;
    return int'(v);
  endfunction

  // Greedy walk from the highest index down, then one word per index going up.
  task automatic push_change_breakdown(input logic [15:0] total);
    int          k;
    int          i;
    logic [15:0] rem;
    logic [15:0] cnt [gcoin_pkg::MAX_COIN_KINDS];
    coin_word_t  w;
    k = active_kinds(kinds_reg);
    rem = total;
    for (i = 0; i < gcoin_pkg::MAX_COIN_KINDS; i++) cnt[i] = '0;
    for (i = k - 1; i >= 0; i--) begin
      // Zero coins are skipped and keep a count of zero.
      if (denom_tbl[i] != '0) begin
        cnt[i] = rem / denom_tbl[i];
        rem = rem % denom_tbl[i];
      end
    end
    for (i = 0; i < k; i++) begin
      w.coin_slot = 4'(i);
      w.coin_count = cnt[i];
      w.unpaid = rem;
      w.last = (i == k - 1);
      expected_coins.push_back(w);
    end
  endtask

  // Present one input word, wait for it to be taken, then record what it should do.
  task automatic send_word(input logic action, input logic [3:0] slot,
                           input logic [15:0] amount, input logic typed,
                           input logic [15:0] exp_count, input logic [15:0] exp_unpaid);
    coin_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_slot <= slot;
    in_amount <= amount;
    do @(posedge clk); while (in_stall);
    if (action == gcoin_pkg::ACT_LOAD) begin
      denom_tbl[slot] = amount;
      written[slot] = 1'b1;
    end else if (typed) begin
      w.coin_slot = '0;
      w.coin_count = exp_count;
      w.unpaid = exp_unpaid;
      w.last = 1'b1;
      expected_coins.push_back(w);
    end else begin
      push_change_breakdown(amount);
    end
  endtask

  // Stop sending and let every expected word drain out, plus a short tail for a load.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_coins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_kinds(input logic [4:0] v);
    settle_block();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    kinds_reg = v;
  endtask

  // Coin values that give nontrivial counts most of the time.
  function automatic logic [15:0] rand_denom();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'd0;
    if (pick < 60) return 16'($urandom_range(64, 1));
    if (pick < 85) return 16'($urandom_range(1024, 1));
    return 16'($urandom_range(65535, 1));
  endfunction

  // Result side: random stall and comparison against the oldest expected word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_coins.size() == 0) begin
        $error("result word with no request pending: coin_slot %0d", out_coin_slot);
        fails++;
      end else begin
        head = expected_coins.pop_front();
        if (out_coin_slot !== head.coin_slot) begin
          $error("coin_slot: expected %0d, actual %0d", head.coin_slot, out_coin_slot);
          fails++;
        end
        if (out_coin_count !== head.coin_count) begin
          $error("coin_count: expected %0d, actual %0d", head.coin_count, out_coin_count);
          fails++;
        end
        if (out_unpaid !== head.unpaid) begin
          $error("unpaid: expected %0d, actual %0d", head.unpaid, out_unpaid);
          fails++;
        end
        if (out_last !== head.last) begin
          $error("last: expected %0d, actual %0d", head.last, out_last);
          fails++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    int r;
    int ph;
    int n;
    int s;
    int k;
    int pick;
    logic [15:0] amt;

    for (s = 0; s < gcoin_pkg::MAX_COIN_KINDS; s++) denom_tbl[s] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    send_idle_pct = 12;
    recv_stall_pct = 61;
    for (r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].is_kinds)
        write_kinds(directed_rows[r].amount[4:0]);
      else
        send_word(directed_rows[r].action, directed_rows[r].slot, directed_rows[r].amount,
                  directed_rows[r].typed, directed_rows[r].exp_count,
                  directed_rows[r].exp_unpaid);
    end

    // Random phases: one register setting each, idling pattern changes every third phase.
    phase_kinds[4] = 5'($urandom_range(31));
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      unique case (ph / 3)
        0: begin
          send_idle_pct = 12;
          recv_stall_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_kinds(phase_kinds[ph]);
      k = active_kinds(kinds_reg);

      // Every coin a request can read must be loaded first.
      for (s = 0; s < k; s++)
        if (!written[s]) send_word(gcoin_pkg::ACT_LOAD, 4'(s), rand_denom(), 1'b0, '0, '0);

      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        // Hold off once mid-phase until the block has emptied.
        if (ph == 4 && n == 12) settle_block();
        if ($urandom_range(99) < 35) begin
          send_word(gcoin_pkg::ACT_LOAD, 4'($urandom_range(15)), rand_denom(),
                    1'b0, '0, '0);
        end else begin
          pick = $urandom_range(99);
          if (pick < 10) amt = 16'd0;
          else if (pick < 20) amt = 16'hFFFF;
          else amt = 16'($urandom_range(65535));
          send_word(gcoin_pkg::ACT_CHANGE, 4'($urandom_range(15)), amt, 1'b0, '0, '0);
        end
      end
    end

    settle_block();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
